// File: rtl/core/bdpt_pkg.sv
// Package: shared types, register map and constants for the button debounce press timer.
package bdpt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [DATA_W-1:0] PRESS_PATTERN   = 32'h0000_00FF;
  localparam logic [DATA_W-1:0] RELEASE_PATTERN = 32'hFF00_0000;
  localparam logic [DATA_W-1:0] ALL_ONES        = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ZEROS       = 32'h0000_0000;

  localparam logic [DATA_W-1:0] MATCH_MASK_RST  = 32'hFF00_00FF;
  localparam logic [DATA_W-1:0] SHORT_LIMIT_RST = 32'd500;
  localparam logic [DATA_W-1:0] LONG_LIMIT_RST  = 32'd2000;

  typedef enum logic [1:0] {
    REG_MATCH_MASK  = 2'd0,
    REG_SHORT_LIMIT = 2'd1,
    REG_LONG_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_VLONG = 2'd3
  } press_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] match_mask;
    logic [DATA_W-1:0] short_limit;
    logic [DATA_W-1:0] long_limit;
  } cfg_t;

endpackage

// File: rtl/core/bdpt_if.sv
// Interfaces: input sample channel and result channel, valid/ready handshake.
interface bdpt_in_if;
  logic        valid;
  logic        ready;
  logic        sample;
  logic [31:0] timestamp;

  modport source (output valid, sample, timestamp, input ready);
  modport sink   (input valid, sample, timestamp, output ready);
endinterface

interface bdpt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_kind;
  logic       press_seen;
  logic       is_up;
  logic       is_down;

  modport source (output valid, press_kind, press_seen, is_up, is_down, input ready);
  modport sink   (input valid, press_kind, press_seen, is_up, is_down, output ready);
endinterface

// File: rtl/core/button_debounce_press_timer_top.sv
// An accepted request is held in the input register, then moves to the result register once that is free or read.
// Throughput: one request per cycle while out_ch.ready is high; input register and result register
// each hold one request, so input is taken while a result waits.
// The history/press-start update is combinational logic.
// Reset (rst_n low, synchronous): history and press start cleared, both
// stages empty, match_mask 0xFF0000FF, short_limit 500, long_limit 2000.
module button_debounce_press_timer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  bdpt_in_if.sink                       in_ch,
  bdpt_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdpt_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdpt_pkg::DATA_W-1:0]   pwdata,
  output logic [bdpt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  bdpt_pkg::cfg_t cfg;

  bdpt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdpt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/core/bdpt_cfg.sv
// Configuration registers behind an APB-style port.
module bdpt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdpt_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdpt_pkg::DATA_W-1:0]   pwdata,
  output logic [bdpt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bdpt_pkg::cfg_t                cfg
);

  bdpt_pkg::cfg_t     cfg_r;
  bdpt_pkg::cfg_t     cfg_nxt;
  bdpt_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = bdpt_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        bdpt_pkg::REG_MATCH_MASK:  cfg_nxt.match_mask  = pwdata;
        bdpt_pkg::REG_SHORT_LIMIT: cfg_nxt.short_limit = pwdata;
        bdpt_pkg::REG_LONG_LIMIT:  cfg_nxt.long_limit  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdpt_pkg::REG_MATCH_MASK:  prdata = cfg_r.match_mask;
      bdpt_pkg::REG_SHORT_LIMIT: prdata = cfg_r.short_limit;
      bdpt_pkg::REG_LONG_LIMIT:  prdata = cfg_r.long_limit;
      default:                   prdata = bdpt_pkg::ALL_ZEROS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_mask  <= bdpt_pkg::MATCH_MASK_RST;
      cfg_r.short_limit <= bdpt_pkg::SHORT_LIMIT_RST;
      cfg_r.long_limit  <= bdpt_pkg::LONG_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/bdpt_core.sv
// Debounce datapath: input register, history/press-start state, classify, result register.
module bdpt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bdpt_pkg::cfg_t    cfg,
  bdpt_in_if.sink           in_ch,
  bdpt_out_if.source        out_ch
);

  // input stage
  logic                        in_vld_r;
  logic                        sample_r;
  logic [bdpt_pkg::DATA_W-1:0] stamp_r;
  // state
  logic [bdpt_pkg::DATA_W-1:0] history_r;
  logic [bdpt_pkg::DATA_W-1:0] history_nxt;
  logic [bdpt_pkg::DATA_W-1:0] start_r;
  logic [bdpt_pkg::DATA_W-1:0] start_nxt;
  // result stage
  logic                        out_vld_r;
  bdpt_pkg::press_kind_t       kind_r;
  bdpt_pkg::press_kind_t       kind_nxt;
  logic                        seen_r;
  logic                        up_r;
  logic                        down_r;

  logic                        advance;
  logic                        in_take;
  logic [bdpt_pkg::DATA_W-1:0] hist_shift;
  logic [bdpt_pkg::DATA_W-1:0] hist_press;
  logic                        press_hit;
  logic                        rel_hit;
  logic [bdpt_pkg::DATA_W-1:0] span;

  assign advance     = in_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready = ~in_vld_r | advance;
  assign in_take     = in_ch.valid & in_ch.ready;

  always_comb begin
    hist_shift = {history_r[bdpt_pkg::DATA_W-2:0], sample_r};
    press_hit  = (hist_shift & cfg.match_mask) == bdpt_pkg::PRESS_PATTERN;
    hist_press = press_hit ? bdpt_pkg::ALL_ONES : hist_shift;
    start_nxt  = press_hit ? stamp_r : start_r;
    // press check runs first, so release sees the forced history
    rel_hit    = (hist_press & cfg.match_mask) == bdpt_pkg::RELEASE_PATTERN;
    span       = stamp_r - start_nxt;
    history_nxt = rel_hit ? bdpt_pkg::ALL_ZEROS : hist_press;
    if (!rel_hit) begin
      kind_nxt = bdpt_pkg::KIND_NONE;
    end else if (span < cfg.short_limit) begin
      kind_nxt = bdpt_pkg::KIND_SHORT;
    end else if (span < cfg.long_limit) begin
      kind_nxt = bdpt_pkg::KIND_LONG;
    end else begin
      kind_nxt = bdpt_pkg::KIND_VLONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      history_r <= bdpt_pkg::ALL_ZEROS;
      start_r   <= bdpt_pkg::ALL_ZEROS;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        history_r <= history_nxt;
        start_r   <= start_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_ch.sample;
      stamp_r  <= in_ch.timestamp;
    end
    if (advance) begin
      kind_r <= kind_nxt;
      seen_r <= press_hit;
      up_r   <= history_nxt == bdpt_pkg::ALL_ZEROS;
      down_r <= history_nxt == bdpt_pkg::ALL_ONES;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.press_kind = kind_r;
  assign out_ch.press_seen = seen_r;
  assign out_ch.is_up      = up_r;
  assign out_ch.is_down    = down_r;

endmodule
